/* rtl/scqc_pkg.sv */
package scqc_pkg;
	localparam int CfgIdxBits = 2;
	localparam int CfgDataBits = 11;
	localparam logic [CfgIdxBits-1:0] CFG_CENTER_X = 2'd0;
	localparam logic [CfgIdxBits-1:0] CFG_CENTER_Y = 2'd1;
	localparam logic [CfgIdxBits-1:0] CFG_COORD_LIMIT = 2'd2;
	localparam logic [9:0] CENTER_X_RESET = 10'd480;
	localparam logic [9:0] CENTER_Y_RESET = 10'd270;
	localparam logic [10:0] COORD_LIMIT_RESET = 11'd1200;
	localparam int PtBits = 11;
	localparam int DistBits = 12;
	localparam logic [DistBits-1:0] DIST_ALL_ONES = '1;

	typedef struct packed {
		logic [PtBits-1:0] px;
		logic [PtBits-1:0] py;
		logic              ok;
		logic              last;
	} pt_word_t;
endpackage

/* rtl/scqc_front.sv */
module scqc_front
	import scqc_pkg::*;
#(
	parameter int COORD_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] fsx,
	input  logic [COORD_BITS-1:0] fsy,
	input  logic [COORD_BITS-1:0] fex,
	input  logic [COORD_BITS-1:0] fey,
	input  logic [COORD_BITS-1:0] ssx,
	input  logic [COORD_BITS-1:0] ssy,
	input  logic [COORD_BITS-1:0] sex,
	input  logic [COORD_BITS-1:0] sey,
	input  logic                  last_in,
	input  logic [10:0]           coord_limit,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pt_word_t              out_word
);
	localparam int DB = COORD_BITS + 2;
	localparam int PB = 2 * DB + 1;
	localparam int NB = 3 * DB + COORD_BITS + 4;
	localparam int LB = PB + 12;
	localparam int QB = NB;
	localparam int CB = $clog2(QB + 1);

	typedef enum logic [2:0] {S_IDLE, S_M1, S_M2, S_M3, S_CHK, S_DIVX, S_DIVY, S_OUT}
		state_t;
	state_t state_q;

	logic signed [DB-1:0] x1_q, y1_q, x2_q, y2_q, x21_q, y21_q, fsx_q, fsy_q, ssx_q, ssy_q;
	logic signed [PB-1:0] det_q, pa_q, pb_q, pc_q, pd_q;
	logic signed [NB-1:0] nx_q, ny_q;
	logic                 last_q;
	logic [NB-1:0]        rem_q, quo_q, num_q;
	logic [CB-1:0]        cnt_q;
	logic [PtBits-1:0]    px_q;

	logic signed [PB-1:0] det_abs;
	logic signed [NB-1:0] nxa, nya, lim;
	logic [NB:0]          trial;

	assign det_abs = det_q[PB-1] ? -det_q : det_q;
	assign nxa = det_q[PB-1] ? -nx_q : nx_q;
	assign nya = det_q[PB-1] ? -ny_q : ny_q;
	assign lim = NB'($signed({1'b0, coord_limit})) * NB'(det_abs);
	assign trial = {rem_q, num_q[NB-1]} - {1'b0, NB'(det_abs)};
	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						x1_q <= DB'(fex) - DB'(fsx);
						y1_q <= DB'(fey) - DB'(fsy);
						x2_q <= DB'(sex) - DB'(ssx);
						y2_q <= DB'(sey) - DB'(ssy);
						x21_q <= DB'(ssx) - DB'(fsx);
						y21_q <= DB'(ssy) - DB'(fsy);
						fsx_q <= DB'(fsx);
						fsy_q <= DB'(fsy);
						ssx_q <= DB'(ssx);
						ssy_q <= DB'(ssy);
						last_q <= last_in;
						state_q <= S_M1;
					end
				end
				S_M1: begin
					pa_q <= PB'(x1_q * x2_q);
					pb_q <= PB'(y1_q * x2_q);
					pc_q <= PB'(y2_q * x1_q);
					pd_q <= PB'(y1_q * y2_q);
					state_q <= S_M2;
				end
				S_M2: begin
					det_q <= pb_q - pc_q;
					nx_q <= NB'(pa_q * y21_q);
					ny_q <= -NB'(pd_q * x21_q);
					state_q <= S_M3;
				end
				S_M3: begin
					nx_q <= nx_q + NB'(pb_q * fsx_q) - NB'(pc_q * ssx_q);
					ny_q <= ny_q - NB'(pc_q * fsy_q) + NB'(pb_q * ssy_q);
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (det_q == '0 || nxa <= 0 || nya <= 0 || nxa > lim || nya > lim) begin
						out_word <= '{px: '0, py: '0, ok: 1'b0, last: last_q};
						out_valid <= 1'b1;
						state_q <= S_OUT;
					end else begin
						ny_q <= nya;
						num_q <= nxa;
						rem_q <= '0;
						cnt_q <= '0;
						state_q <= S_DIVX;
					end
				end
				S_DIVX, S_DIVY: begin
					num_q <= num_q << 1;
					if (!trial[NB]) begin
						rem_q <= trial[NB-1:0];
						quo_q <= {quo_q[NB-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[NB-2:0], num_q[NB-1]};
						quo_q <= {quo_q[NB-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CB'(QB - 1)) begin
						cnt_q <= '0;
						if (state_q == S_DIVX) begin
							px_q <= PtBits'(!trial[NB] ? {quo_q[NB-2:0], 1'b1}
								: {quo_q[NB-2:0], 1'b0});
							num_q <= ny_q;
							rem_q <= '0;
							state_q <= S_DIVY;
						end else begin
							out_word <= '{px: px_q,
								py: PtBits'(!trial[NB] ? {quo_q[NB-2:0], 1'b1}
									: {quo_q[NB-2:0], 1'b0}),
								ok: 1'b1, last: last_q};
							out_valid <= 1'b1;
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* rtl/scqc_fifo.sv */
module scqc_fifo
	import scqc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  pt_word_t in_word,
	output logic     out_valid,
	input  logic     out_ready,
	output pt_word_t out_word
);
	pt_word_t mem_q [2];
	logic     wp_q, rp_q;
	logic [1:0] cnt_q;
	logic     wr, rd;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_word = mem_q[rp_q];
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule

/* rtl/scqc_back.sv */
module scqc_back
	import scqc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pt_word_t          in_word,
	input  logic [9:0]        center_x,
	input  logic [9:0]        center_y,
	output logic              empty,
	input  logic              pop,
	output logic [1:0]        corner_id,
	output logic [PtBits-1:0] corner_x,
	output logic [PtBits-1:0] corner_y,
	output logic              corner_found,
	output logic              last_corner
);
	typedef enum logic [1:0] {S_IDLE, S_BIN, S_SQRT, S_EMIT} state_t;
	state_t state_q;

	logic [PtBits-1:0]   col_q [4];
	logic [PtBits-1:0]   row_q [4];
	logic [DistBits-1:0] dist_q [4];
	logic [3:0]          found_q;
	logic [1:0]          quad_q, id_q;
	logic                last_q;
	logic [PtBits-1:0]   px_q, py_q;
	logic [23:0]         v_q;
	logic [23:0]         res_q, bit_q;

	logic signed [PtBits:0] dx, dy;
	logic                   xl, xg, yl, yg;
	logic [1:0]             quad;
	logic                   on_axis;
	logic [23:0]            sum;

	assign xl = px_q < PtBits'(center_x);
	assign xg = px_q > PtBits'(center_x);
	assign yl = py_q < PtBits'(center_y);
	assign yg = py_q > PtBits'(center_y);
	assign on_axis = !(xl || xg) || !(yl || yg);
	assign quad = (xl && yl) ? 2'd0 : (xg && yl) ? 2'd1 : (xg && yg) ? 2'd2 : 2'd3;
	assign dx = $signed({1'b0, px_q}) - $signed({2'b0, center_x});
	assign dy = $signed({1'b0, py_q}) - $signed({2'b0, center_y});
	assign sum = res_q + bit_q;
	assign in_ready = (state_q == S_IDLE);
	assign empty = (state_q != S_EMIT);
	assign corner_id = id_q;
	assign corner_found = found_q[id_q];
	assign corner_x = found_q[id_q] ? col_q[id_q] : '0;
	assign corner_y = found_q[id_q] ? row_q[id_q] : '0;
	assign last_corner = (id_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			found_q <= '0;
			id_q <= '0;
			for (int i = 0; i < 4; i++) begin
				dist_q[i] <= DIST_ALL_ONES;
				col_q[i] <= '0;
				row_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						last_q <= in_word.last;
						px_q <= in_word.px;
						py_q <= in_word.py;
						if (in_word.ok) begin
							state_q <= S_BIN;
						end else if (in_word.last) begin
							id_q <= '0;
							state_q <= S_EMIT;
						end
					end
				end
				S_BIN: begin
					if (on_axis) begin
						if (last_q) begin
							id_q <= '0;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						quad_q <= quad;
						v_q <= 24'(dx * dx) + 24'(dy * dy);
						res_q <= '0;
						bit_q <= 24'h400000;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (bit_q != '0) begin
						if (v_q >= sum) begin
							v_q <= v_q - sum;
							res_q <= (res_q >> 1) + bit_q;
						end else begin
							res_q <= res_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end else begin
						if (DistBits'(res_q) < dist_q[quad_q]) begin
							dist_q[quad_q] <= DistBits'(res_q);
							col_q[quad_q] <= px_q;
							row_q[quad_q] <= py_q;
							found_q[quad_q] <= 1'b1;
						end
						if (last_q) begin
							id_q <= '0;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_EMIT: begin
					if (pop) begin
						id_q <= id_q + 1'b1;
						if (id_q == 2'd3) begin
							found_q <= '0;
							for (int i = 0; i < 4; i++) begin
								dist_q[i] <= DIST_ALL_ONES;
								col_q[i] <= '0;
								row_q[i] <= '0;
							end
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* rtl/segment_cross_quadrant_corners_top.sv */
// Corner picker: each word pushed is a pair of segments; their lines are
// intersected with truncating division, and a crossing off the center's axes
// is binned into a quadrant around the center, keeping the nearest point per
// quadrant. A word with last_pair set yields four corner words (ids 0..3).
// The front end runs three multiply steps and a check on a pair, then two
// bit-serial divisions of 4*COORD_BITS+10 steps each; a dropped pair skips
// the divisions. The back end bins each point and takes its integer square
// root. A two-entry queue lets the next pair start while a point is binned.
// The user must write configuration only while idle; the block has no check.
module segment_cross_quadrant_corners_top
	import scqc_pkg::*;
#(
	parameter int COORD_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [COORD_BITS-1:0]  first_start_x,
	input  logic [COORD_BITS-1:0]  first_start_y,
	input  logic [COORD_BITS-1:0]  first_end_x,
	input  logic [COORD_BITS-1:0]  first_end_y,
	input  logic [COORD_BITS-1:0]  second_start_x,
	input  logic [COORD_BITS-1:0]  second_start_y,
	input  logic [COORD_BITS-1:0]  second_end_x,
	input  logic [COORD_BITS-1:0]  second_end_y,
	input  logic                   last_pair,
	input  logic                   cfg_we,
	input  logic [CfgIdxBits-1:0]  cfg_index,
	input  logic [CfgDataBits-1:0] cfg_data,
	output logic                   empty,
	input  logic                   pop,
	output logic [1:0]             corner_id,
	output logic [PtBits-1:0]      corner_x,
	output logic [PtBits-1:0]      corner_y,
	output logic                   corner_found,
	output logic                   last_corner
);
	logic [9:0]  center_x_q, center_y_q;
	logic [10:0] coord_limit_q;
	logic        f_valid, f_ready, b_valid, b_ready, in_ready;
	pt_word_t    f_word, b_word;

	assign full = !in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= CENTER_X_RESET;
			center_y_q <= CENTER_Y_RESET;
			coord_limit_q <= COORD_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CENTER_X: center_x_q <= cfg_data[9:0];
				CFG_CENTER_Y: center_y_q <= cfg_data[9:0];
				CFG_COORD_LIMIT: coord_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	scqc_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk, .arst_n, .in_valid(push), .in_ready,
		.fsx(first_start_x), .fsy(first_start_y), .fex(first_end_x), .fey(first_end_y),
		.ssx(second_start_x), .ssy(second_start_y), .sex(second_end_x),
		.sey(second_end_y), .last_in(last_pair), .coord_limit(coord_limit_q),
		.out_valid(f_valid), .out_ready(f_ready), .out_word(f_word)
	);

	scqc_fifo u_fifo (
		.clk, .arst_n, .in_valid(f_valid), .in_ready(f_ready), .in_word(f_word),
		.out_valid(b_valid), .out_ready(b_ready), .out_word(b_word)
	);

	scqc_back u_back (
		.clk, .arst_n, .in_valid(b_valid), .in_ready(b_ready), .in_word(b_word),
		.center_x(center_x_q), .center_y(center_y_q), .empty, .pop,
		.corner_id, .corner_x, .corner_y, .corner_found, .last_corner
	);
endmodule
